[src/assert_macros.svh]
// assert_macros.svh: assertion macros for the list engine checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/ilt_pkg.sv]
// ilt_pkg: list size, mode and status codes and result type for the list engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ilt_pkg;
  localparam int ILT_DEPTH      = 64;
  localparam int ILT_VALUE_BITS = 32;

  localparam logic [2:0] MODE_CLEAR    = 3'd0;
  localparam logic [2:0] MODE_INSERT   = 3'd1;
  localparam logic [2:0] MODE_DELETE   = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_WRITE    = 3'd4;
  localparam logic [2:0] MODE_SEARCH   = 3'd5;
  localparam logic [2:0] MODE_SORT     = 3'd6;
  localparam logic [2:0] MODE_RESERVED = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [5:0]  found_position;
    logic [6:0]  entry_count;
  } result_t;
endpackage
`default_nettype wire

[src/ilt_ram.sv]
// ilt_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ilt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/ilt_ctrl.sv]
// ilt_ctrl: sequencer for list requests over the entry and scratch RAMs.
// Depends on ilt_pkg and ilt_ram.
`timescale 1ns / 1ps
`default_nettype none
module ilt_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [2:0]                          mode,
  input  wire logic [6:0]                          position,
  input  wire logic [ilt_pkg::ILT_VALUE_BITS-1:0] value_in,
  input  wire logic [6:0]                          capacity,
  output logic                                     busy,
  output logic                                     done,
  output ilt_pkg::result_t                         result
);
  import ilt_pkg::*;
  localparam int DEPTH      = ILT_DEPTH;
  localparam int VALUE_BITS = ILT_VALUE_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_INS = 4'd1, S_DEL = 4'd2, S_RD = 4'd3,
                         S_SRCH = 4'd4, S_PASS = 4'd5, S_MRG = 4'd6, S_CPY = 4'd7,
                         S_FIN = 4'd8, S_RDW = 4'd9;

  logic [3:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         pos;
  logic [VALUE_BITS-1:0] val;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] vout;
  logic [5:0]            fpos;
  logic                  rvalid;
  // merge pointers
  logic [CW-1:0] width, mid, hi, pi, pj, pk;
  logic [1:0]    mph;

  logic                  e_we, s_we;
  logic [AW-1:0]         e_wa, e_ra, s_wa, s_ra;
  logic [VALUE_BITS-1:0] e_wd, s_wd, e_rd, s_rd;
  logic [VALUE_BITS-1:0] a_val, b_val;

  ilt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  ilt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  logic [CW-1:0] cap;
  assign cap = (capacity > 7'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);

  assign busy = (state != S_IDLE);

  // merge: phase 0 read a, phase 1 read b, phase 2 compare and write
  logic a_ok, b_ok, take_b;
  assign b_val  = e_rd;
  assign a_ok   = (pi < mid);
  assign b_ok   = (pj < hi);
  assign take_b = !a_ok || (b_ok && ($signed(b_val) < $signed(a_val)));

  always_comb begin
    e_we = 1'b0; e_wa = '0; e_wd = val; e_ra = '0;
    s_we = 1'b0; s_wa = pk[AW-1:0]; s_wd = take_b ? b_val : a_val; s_ra = '0;
    case (state)
      S_INS: begin
        e_ra = AW'(idx - 1'b1);
        if (rvalid) begin
          e_we = 1'b1; e_wa = idx[AW-1:0]; e_wd = e_rd;
        end
      end
      S_DEL: begin
        e_ra = AW'(idx + 1'b1);
        if (rvalid) begin
          e_we = 1'b1; e_wa = idx[AW-1:0]; e_wd = e_rd;
        end
      end
      S_RD: e_ra = pos[AW-1:0];
      S_RDW: begin
        e_we = 1'b1; e_wa = pos[AW-1:0];
      end
      S_SRCH: e_ra = idx[AW-1:0];
      S_MRG: begin
        e_ra = (mph == 2'd0) ? pi[AW-1:0] : pj[AW-1:0];
        s_we = (mph == 2'd2);
      end
      S_CPY: begin
        s_ra = idx[AW-1:0];
        if (rvalid) begin
          e_we = 1'b1; e_wa = AW'(idx - 1'b1); e_wd = s_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          pos <= CW'(position); val <= value_in;
          status <= ST_OK; vout <= '0; fpos <= '0; rvalid <= 1'b0;
          case (mode)
            MODE_CLEAR: begin count <= '0; state <= S_FIN; end
            MODE_INSERT:
              if (count >= cap) begin status <= ST_FULL; state <= S_FIN; end
              else if (7'(position) > 7'(count)) begin
                status <= ST_RANGE; state <= S_FIN;
              end else begin idx <= count; state <= S_INS; end
            MODE_DELETE, MODE_READ, MODE_WRITE:
              if (7'(position) >= 7'(count)) begin
                status <= ST_RANGE; state <= S_FIN;
              end else if (mode == MODE_DELETE) begin
                idx <= CW'(position); state <= S_DEL;
              end else if (mode == MODE_READ) state <= S_RD;
              else state <= S_RDW;
            MODE_SEARCH: begin status <= ST_NOTFOUND; idx <= '0; state <= S_SRCH; end
            MODE_SORT: begin width <= CW'(1); state <= S_PASS; end
            default: state <= S_FIN;
          endcase
        end
        S_INS: begin
          if (idx == pos) state <= S_RDW;
          else if (rvalid) begin rvalid <= 1'b0; idx <= idx - 1'b1; end
          else rvalid <= 1'b1;
          if (idx == pos) count <= count + 1'b1;
        end
        S_DEL: begin
          if (idx + 1'b1 >= count) begin count <= count - 1'b1; state <= S_FIN; end
          else if (rvalid) begin rvalid <= 1'b0; idx <= idx + 1'b1; end
          else rvalid <= 1'b1;
        end
        S_RD: begin
          if (rvalid) begin vout <= e_rd; state <= S_FIN; end
          rvalid <= 1'b1;
        end
        S_RDW: state <= S_FIN;
        S_SRCH: begin
          if (rvalid && e_rd == val) begin
            status <= ST_OK; fpos <= 6'(idx - 1'b1); state <= S_FIN;
          end else if (idx >= count) state <= S_FIN;
          else begin idx <= idx + 1'b1; rvalid <= 1'b1; end
        end
        S_PASS: begin
          if (width >= count) state <= S_FIN;
          else begin
            pi <= '0; pk <= '0;
            mid <= (width > count) ? count : width;
            pj  <= (width > count) ? count : width;
            hi  <= ((CW+1)'({width, 1'b0}) > (CW+1)'(count)) ? count : CW'({width, 1'b0});
            mph <= 2'd0; state <= S_MRG;
          end
        end
        S_MRG: begin
          case (mph)
            2'd0: mph <= 2'd1;
            2'd1: begin a_val <= e_rd; mph <= 2'd2; end
            default: begin
              pk <= pk + 1'b1;
              if (take_b) pj <= pj + 1'b1; else pi <= pi + 1'b1;
              if (pk + 1'b1 >= hi) begin
                if (hi >= count) begin idx <= '0; rvalid <= 1'b0; state <= S_CPY; end
                else begin
                  pi <= hi; mph <= 2'd0;
                  mid <= ((CW+1)'(hi) + (CW+1)'(width) > (CW+1)'(count)) ? count
                         : CW'(hi + width);
                  pj  <= ((CW+1)'(hi) + (CW+1)'(width) > (CW+1)'(count)) ? count
                         : CW'(hi + width);
                  hi  <= ((CW+1)'(hi) + (CW+1)'({width, 1'b0}) > (CW+1)'(count))
                         ? count : CW'(hi + {width, 1'b0});
                end
              end else mph <= 2'd0;
            end
          endcase
        end
        S_CPY: begin
          if (idx >= count) begin width <= {width[CW-2:0], 1'b0}; state <= S_PASS; end
          else idx <= idx + 1'b1;
          rvalid <= 1'b1;
          if (rvalid && idx >= count) rvalid <= 1'b0;
        end
        S_FIN: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.status = status;
  assign result.value_out = 32'(vout);
  assign result.found_position = fpos;
  assign result.entry_count = 7'(count);
endmodule
`default_nettype wire

[src/indexed_list_table_engine.sv]
// indexed_list_table_engine: top level, stream ports and output register.
// Depends on ilt_pkg and ilt_ctrl.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: a new request word is taken only once the previous
// result word has left. Clear, read, overwrite and refused requests give their
// result word without walking the list; insert and delete move one entry at a
// time, search checks one entry per cycle; sort does ceil(log2(count)) merge
// passes, reading both merge inputs through the single read port of the entry
// RAM, each pass followed by a copy back from the scratch RAM.
module indexed_list_table_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // mode, position, value_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata   // status, value_out, found_position, entry_count
);
  import ilt_pkg::*;
  logic [6:0] capacity_limit;
  logic busy, done;
  result_t res;
  always_ff @(posedge clk) begin
    if (rst) capacity_limit <= 7'd64;
    else if (cfg_we) capacity_limit <= cfg_wdata;
  end
  assign s_tready = !busy && !done && !m_tvalid;
  ilt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(s_tvalid && s_tready), .mode(s_tdata[2:0]),
    .position(s_tdata[9:3]), .value_in(s_tdata[41:10]),
    .capacity(capacity_limit), .busy(busy), .done(done), .result(res));
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) m_tdata <= {1'b0, res.entry_count, res.found_position, res.value_out,
                          res.status};
  end
endmodule
`default_nettype wire

[src/ilt_checker.sv]
// ilt_checker: port-level assertions for the list engine, bound to the top.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ilt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);
  `CHK_IMPLY(a_one_at_a_time, clk, rst, m_tvalid, !s_tready, "input taken while result held")
  `CHK_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `CHK_NEXT(a_busy, clk, rst, s_tvalid && s_tready, !s_tready, "second request accepted")
  `CHK_IMPLY(a_count, clk, rst, m_tvalid, m_tdata[46:40] <= 7'd64, "count over depth")
endmodule
bind indexed_list_table_engine ilt_checker u_chk (.*);
`default_nettype wire
